[rtl/five_channel_prescaled_timer_macros.svh]
// Assertion macros shared by the timer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef FIVE_CHANNEL_PRESCALED_TIMER_MACROS_SVH
`define FIVE_CHANNEL_PRESCALED_TIMER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FCPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FCPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FCPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define FCPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/fcpt_pkg.sv]
// Package for the prescaled timer block: widths, register map, control bit layout.
// No dependencies.
`timescale 1ns / 1ps

package fcpt_pkg;

	localparam int NUM_TIMERS_DEF  = 5;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int MAX_TIMERS      = 5;
	localparam int MAX_CMP         = 4;   // the last timer has no compare register
	localparam int LOW_GROUP_SIZE  = 2;   // timers below this use the low prescaler

	localparam int REQ_TYPE_W = 2;
	localparam int REG_IDX_W  = 4;
	localparam int DATA_W     = 32;
	localparam int IRQ_W      = 5;
	localparam int CTRL_W     = 23;
	localparam int PHASE_W    = 12;
	localparam int STEP_W     = 13;
	localparam int PRE_W      = 8;
	localparam int SEL_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2
	} req_type_t;

	// register map
	localparam int REG_CNT_BUF0 = 0;
	localparam int REG_CMP_BUF0 = 5;
	localparam int REG_CNT_OBS0 = 9;
	localparam int REG_CTRL     = 14;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_HIGH = 3'd1;
	localparam int                   CFG_DIV_SEL0      = 2;
	localparam int                   CFG_LAST          = CFG_DIV_SEL0 + MAX_TIMERS - 1;

	// control word layout per timer
	localparam int START_POS  [MAX_TIMERS] = '{0, 8, 12, 16, 20};
	localparam int UPDATE_POS [MAX_TIMERS] = '{1, 9, 13, 17, 21};
	localparam int RELOAD_POS [MAX_TIMERS] = '{3, 11, 15, 19, 22};

endpackage

[rtl/fcpt_req_if.sv]
// Request channel: valid/ready handshake with request type, register index and data.
// Depends on fcpt_pkg.
`timescale 1ns / 1ps

interface fcpt_req_if;
	import fcpt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [REG_IDX_W-1:0]  reg_index;
	logic [DATA_W-1:0]     write_data;

	modport source (output valid, req_type, reg_index, write_data, input ready);
	modport sink   (input valid, req_type, reg_index, write_data, output ready);
endinterface

[rtl/fcpt_rsp_if.sv]
// Response channel: valid/ready handshake with read data and interrupt pulses.
// Depends on fcpt_pkg.
`timescale 1ns / 1ps

interface fcpt_rsp_if;
	import fcpt_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [IRQ_W-1:0]  irq_pulses;

	modport source (output valid, read_data, irq_pulses, input ready);
	modport sink   (input valid, read_data, irq_pulses, output ready);
endinterface

[rtl/five_channel_prescaled_timer.sv]
// Top level of the prescaled timer block: register file, timers, output buffer.
// Depends on fcpt_pkg, fcpt_req_if, fcpt_rsp_if and the assertion macro header.
//
// Usage: every transfer on req is one peripheral event: a clock tick, a register
// read or a register write. Each accepted request produces exactly one transfer
// on rsp carrying read_data (reads only) and irq_pulses (ticks only).
// The cfg port (cfg_we, cfg_index, cfg_data) sets the two prescalers and the
// five divider selects; a write to any defined config register restarts every step phase.
// The response is registered in the output register, or in the skid register while rsp stalls.
// Throughput: one request per cycle while req.ready is high; all timers update in the
// accept cycle through one increment/compare per timer, so nothing limits the rate further.
// A two-entry output buffer (output register plus skid register) lets one more
// request in while a response waits; req.ready drops only once both are full.
// Reset (arst_n low) clears every timer, buffer, control and config register
// and empties the output buffer. There is no clearing sweep after reset.
`timescale 1ns / 1ps
`include "five_channel_prescaled_timer_macros.svh"

module five_channel_prescaled_timer #(
	parameter int NUM_TIMERS  = fcpt_pkg::NUM_TIMERS_DEF,
	parameter int COUNT_WIDTH = fcpt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fcpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcpt_pkg::CFG_DATA_W-1:0] cfg_data,
	fcpt_req_if.sink                        req,
	fcpt_rsp_if.source                      rsp
);
	import fcpt_pkg::*;

	localparam int NUM_CMP = (NUM_TIMERS < MAX_CMP) ? NUM_TIMERS : MAX_CMP;

	logic [PRE_W-1:0]       pre_low_q, pre_high_q;
	logic [SEL_W-1:0]       div_sel_q [NUM_TIMERS];
	logic [CTRL_W-1:0]      ctrl_q;
	logic [CTRL_W-1:0]      clr_mask;
	logic [COUNT_WIDTH-1:0] cnt_buf_q [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] cmp_buf_q [NUM_CMP];
	logic [COUNT_WIDTH-1:0] cnt_q     [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] obs       [NUM_TIMERS];
	logic [PHASE_W-1:0]     phase_q   [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  fire_vec;

	logic              acc, is_tick, is_rd, is_wr, ctrl_wr, cfg_hit;
	logic [DATA_W-1:0] rd_next;
	logic [IRQ_W-1:0]  irq_next;

	logic              out_valid_q, skid_valid_q;
	logic [DATA_W-1:0] out_rd_q, skid_rd_q;
	logic [IRQ_W-1:0]  out_irq_q, skid_irq_q;
	logic              out_free;

	assign acc     = req.valid && req.ready;
	assign is_tick = acc && (req_type_t'(req.req_type) == REQ_TICK);
	assign is_rd   = req_type_t'(req.req_type) == REQ_READ;
	assign is_wr   = acc && (req_type_t'(req.req_type) == REQ_WRITE);
	assign ctrl_wr = is_wr && (req.reg_index == REG_IDX_W'(REG_CTRL));
	assign cfg_hit = cfg_we && (cfg_index <= CFG_IDX_W'(CFG_LAST));

	// prescalers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_low_q  <= '0;
			pre_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRESCALE_LOW:  pre_low_q  <= cfg_data;
				CFG_PRESCALE_HIGH: pre_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control word; expiry without reload drops the start bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (ctrl_wr) begin
			ctrl_q <= req.write_data[CTRL_W-1:0];
		end else begin
			ctrl_q <= ctrl_q & ~clr_mask;
		end
	end

	always_comb begin
		clr_mask = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (fire_vec[i] && !ctrl_q[RELOAD_POS[i]])
				clr_mask[START_POS[i]] = 1'b1;
		end
	end

	genvar n;
	generate
		for (n = 0; n < NUM_TIMERS; n++) begin : g_tmr
			localparam int SP = START_POS[n];
			localparam int UP = UPDATE_POS[n];
			localparam int RP = RELOAD_POS[n];

			logic [PRE_W-1:0]       pre;
			logic [STEP_W-1:0]      step_base, step_len;
			logic [PHASE_W-1:0]     ph_inc;
			logic [COUNT_WIDTH-1:0] cnt_dec;
			logic                   running, step_end, fire;

			assign pre       = (n < LOW_GROUP_SIZE) ? pre_low_q : pre_high_q;
			assign step_base = STEP_W'({1'b0, pre} + 9'd1);
			assign step_len  = (step_base << 1) << div_sel_q[n];
			assign ph_inc    = phase_q[n] + PHASE_W'(1);
			// 12-bit phase wrap also ends the step
			assign step_end  = (ph_inc == '0) || ({1'b0, ph_inc} >= step_len);
			assign cnt_dec   = cnt_q[n] - COUNT_WIDTH'(1);
			assign running   = ctrl_q[SP];
			assign fire      = is_tick && running
				&& ((cnt_q[n] == '0) || (step_end && (cnt_dec == '0)));
			assign fire_vec[n] = fire;

			assign obs[n] = (running && (cnt_q[n] != '0) && (phase_q[n] != '0))
				? cnt_dec : cnt_q[n];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_sel_q[n] <= '0;
				end else if (cfg_we && (cfg_index == CFG_IDX_W'(CFG_DIV_SEL0 + n))) begin
					div_sel_q[n] <= cfg_data[SEL_W-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_buf_q[n] <= '0;
				end else if (is_wr && (req.reg_index == REG_IDX_W'(REG_CNT_BUF0 + n))) begin
					cnt_buf_q[n] <= req.write_data[COUNT_WIDTH-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q[n]   <= '0;
					phase_q[n] <= '0;
				end else begin
					if (ctrl_wr) begin
						if (req.write_data[UP])
							cnt_q[n] <= cnt_buf_q[n];
						if (req.write_data[SP] && !ctrl_q[SP])
							phase_q[n] <= '0;
					end else if (is_tick && running) begin
						if (fire) begin
							phase_q[n] <= '0;
							cnt_q[n]   <= ctrl_q[RP] ? cnt_buf_q[n] : '0;
						end else if (step_end) begin
							phase_q[n] <= '0;
							cnt_q[n]   <= cnt_dec;
						end else begin
							phase_q[n] <= ph_inc;
						end
					end
					if (cfg_hit)
						phase_q[n] <= '0;
				end
			end
		end

		for (n = 0; n < NUM_CMP; n++) begin : g_cmp
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cmp_buf_q[n] <= '0;
				end else if (is_wr && (req.reg_index == REG_IDX_W'(REG_CMP_BUF0 + n))) begin
					cmp_buf_q[n] <= req.write_data[COUNT_WIDTH-1:0];
				end
			end
		end
	endgenerate

	// read mux; unmapped indexes read all ones
	always_comb begin
		rd_next = '0;
		if (is_rd) begin
			rd_next = '1;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (req.reg_index == REG_IDX_W'(REG_CNT_BUF0 + i))
					rd_next = DATA_W'(cnt_buf_q[i]);
				if (req.reg_index == REG_IDX_W'(REG_CNT_OBS0 + i))
					rd_next = DATA_W'(obs[i]);
			end
			for (int i = 0; i < NUM_CMP; i++) begin
				if (req.reg_index == REG_IDX_W'(REG_CMP_BUF0 + i))
					rd_next = DATA_W'(cmp_buf_q[i]);
			end
			if (req.reg_index == REG_IDX_W'(REG_CTRL))
				rd_next = DATA_W'(ctrl_q);
		end
	end

	assign irq_next = IRQ_W'(fire_vec);

	// output register plus skid register
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= acc;
			end
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_rd_q  <= skid_rd_q;
				out_irq_q <= skid_irq_q;
			end else if (acc) begin
				out_rd_q  <= rd_next;
				out_irq_q <= irq_next;
			end
		end
		if (!out_free && acc) begin
			skid_rd_q  <= rd_next;
			skid_irq_q <= irq_next;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_data  = out_rd_q;
	assign rsp.irq_pulses = out_irq_q;

	`FCPT_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid full while output register empty")
	`FCPT_ASSERT_NEXT(a_stall_to_skid, clk, arst_n, acc && out_valid_q && !rsp.ready, skid_valid_q, "stalled transfer not parked in skid")
	`FCPT_ASSERT_NOW(a_irq_on_tick, clk, arst_n, irq_next != '0, is_tick, "interrupt pulse outside a tick")
	`FCPT_ASSERT_NEXT(a_expire_clears, clk, arst_n, (clr_mask != '0) && !ctrl_wr, (ctrl_q & $past(clr_mask)) == '0, "expired timer kept its start bit")

endmodule
